// ----- src/epoch_seconds_to_utc_date_top_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the epoch-to-UTC-date converter
// Shared property wrappers, clocked on aclk and disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef EPOCH_SECONDS_TO_UTC_DATE_TOP_ASSERT_SVH
`define EPOCH_SECONDS_TO_UTC_DATE_TOP_ASSERT_SVH

// same-cycle implication
`define ES2UD_CHK_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ES2UD_CHK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/es2ud_pkg.sv -----
// ----------------------------------------------------------------------------
// es2ud_pkg
// Types, constants and table functions for the epoch-to-UTC-date converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package es2ud_pkg;

    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 40;

    localparam logic [11:0] EPOCH_YEAR = 12'd1970;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_FIX,
        ST_YEAR,
        ST_MONTH
    } state_t;

    typedef enum logic [1:0] {
        DIV_SEC,
        DIV_MIN,
        DIV_HOUR,
        DIV_WDAY
    } div_sel_t;

    typedef struct packed {
        logic     load;
        logic     mul;
        logic     fix;
        div_sel_t div_sel;
        logic     year_step;
        logic     month_step;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        logic year_done;
        logic month_done;
        logic out_free;
    } sts_t;

    // reciprocal of the divisor, rounded down; shift applied in the datapath
    function automatic logic [31:0] div_magic(input div_sel_t sel);
        logic [31:0] m;
        case (sel)
            DIV_SEC:  m = 32'h8888_8888;   // 2^37 / 60
            DIV_MIN:  m = 32'h8888_8888;   // 2^37 / 60
            DIV_HOUR: m = 32'hAAAA_AAAA;   // 2^36 / 24
            DIV_WDAY: m = 32'h9249_2492;   // 2^34 / 7
            default:  m = 32'h8888_8888;
        endcase
        return m;
    endfunction

    function automatic logic [5:0] div_const(input div_sel_t sel);
        logic [5:0] d;
        case (sel)
            DIV_SEC:  d = 6'd60;
            DIV_MIN:  d = 6'd60;
            DIV_HOUR: d = 6'd24;
            DIV_WDAY: d = 6'd7;
            default:  d = 6'd60;
        endcase
        return d;
    endfunction

    // offsets 0..255 span 1970..2225; centuries there are 2000, 2100, 2200
    function automatic logic leap_year(input logic [7:0] off);
        logic [11:0] y;
        y = EPOCH_YEAR + {4'd0, off};
        return (y[1:0] == 2'd0) && (y != 12'd2100) && (y != 12'd2200);
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
        logic [4:0] l;
        case (mon)
            4'd0:    l = 5'd31;
            4'd1:    l = leap ? 5'd29 : 5'd28;
            4'd2:    l = 5'd31;
            4'd3:    l = 5'd30;
            4'd4:    l = 5'd31;
            4'd5:    l = 5'd30;
            4'd6:    l = 5'd31;
            4'd7:    l = 5'd31;
            4'd8:    l = 5'd30;
            4'd9:    l = 5'd31;
            4'd10:   l = 5'd30;
            4'd11:   l = 5'd31;
            default: l = 5'd31;
        endcase
        return l;
    endfunction

endpackage

`default_nettype wire

// ----- src/epoch_seconds_to_utc_date_top.sv -----
// ----------------------------------------------------------------------------
// epoch_seconds_to_utc_date_top
// Unix seconds to broken-down UTC date (time of day, weekday, year, month, day).
//
//  Channel   Dir  tdata fields (low bit first)
//  s_        in   epoch_seconds[31:0]
//  m_        out  second[5:0] minute[11:6] hour[16:12] weekday[19:17]
//                 years_since_1970[27:20] month_index[31:28] day_of_month[36:32]
//
// One transfer at a time: an accept state, then four reciprocal divides
// (60, 60, 24, 7) on one 32x32 multiplier, each a multiply and a fix state,
// then the year walk and the month walk, one year or one month per step.
// Result sits in an output register; the next input is taken while it waits,
// and the month walk holds only if the previous result is still not taken.
// Synchronous active-low reset clears control only.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module epoch_seconds_to_utc_date_top (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [es2ud_pkg::S_DATA_W-1:0] s_tdata,   // epoch_seconds
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [es2ud_pkg::M_DATA_W-1:0]      m_tdata    // second, minute, hour,
                                                           // weekday, years_since_1970,
                                                           // month_index, day_of_month
);

    es2ud_pkg::cmd_t cmd;
    es2ud_pkg::sts_t sts;

    es2ud_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    es2ud_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .sts      (sts),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

`include "epoch_seconds_to_utc_date_top_assert.svh"

    `ES2UD_CHK_SAME(a_fields_range, m_tvalid,
        (m_tdata[5:0] < 6'd60) && (m_tdata[11:6] < 6'd60) && (m_tdata[16:12] < 5'd24)
        && (m_tdata[19:17] < 3'd7) && (m_tdata[31:28] < 4'd12) && (m_tdata[36:32] != 5'd0),
        "result field out of range")
    `ES2UD_CHK_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "accepted while converting")
    `ES2UD_CHK_NEXT(a_result_after_work, !s_tready && cmd.out_load,
        s_tready && m_tvalid, "result load did not complete")

endmodule

`default_nettype wire

// ----- src/es2ud_ctrl.sv -----
// ----------------------------------------------------------------------------
// es2ud_ctrl
// Sequencer: four constant divides, then the year and month walks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module es2ud_ctrl (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_tvalid,
    output logic                 s_tready,
    input  wire es2ud_pkg::sts_t sts,
    output es2ud_pkg::cmd_t      cmd
);

    es2ud_pkg::state_t   state_reg, state_next;
    es2ud_pkg::div_sel_t sel_reg, sel_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= es2ud_pkg::ST_IDLE;
            sel_reg   <= es2ud_pkg::DIV_SEC;
        end else begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        sel_next   = sel_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        cmd.div_sel = sel_reg;
        case (state_reg)
            es2ud_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    sel_next   = es2ud_pkg::DIV_SEC;
                    state_next = es2ud_pkg::ST_MUL;
                end
            end
            es2ud_pkg::ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = es2ud_pkg::ST_FIX;
            end
            es2ud_pkg::ST_FIX: begin
                cmd.fix = 1'b1;
                case (sel_reg)
                    es2ud_pkg::DIV_SEC:  sel_next = es2ud_pkg::DIV_MIN;
                    es2ud_pkg::DIV_MIN:  sel_next = es2ud_pkg::DIV_HOUR;
                    es2ud_pkg::DIV_HOUR: sel_next = es2ud_pkg::DIV_WDAY;
                    default:             sel_next = es2ud_pkg::DIV_SEC;
                endcase
                if (sel_reg == es2ud_pkg::DIV_WDAY) begin
                    state_next = es2ud_pkg::ST_YEAR;
                end else begin
                    state_next = es2ud_pkg::ST_MUL;
                end
            end
            es2ud_pkg::ST_YEAR: begin
                if (sts.year_done) begin
                    state_next = es2ud_pkg::ST_MONTH;
                end else begin
                    cmd.year_step = 1'b1;
                end
            end
            es2ud_pkg::ST_MONTH: begin
                if (sts.month_done) begin
                    if (sts.out_free) begin
                        cmd.out_load = 1'b1;
                        state_next   = es2ud_pkg::ST_IDLE;
                    end
                end else begin
                    cmd.month_step = 1'b1;
                end
            end
            default: begin
                state_next = es2ud_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- src/es2ud_dp.sv -----
// ----------------------------------------------------------------------------
// es2ud_dp
// Datapath: shared reciprocal divider, year/month walk, output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module es2ud_dp (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic [es2ud_pkg::S_DATA_W-1:0]    s_tdata,
    input  wire es2ud_pkg::cmd_t                   cmd,
    output es2ud_pkg::sts_t                        sts,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [es2ud_pkg::M_DATA_W-1:0]         m_tdata
);

    logic [31:0] t_reg, t_next;
    logic [63:0] prod_reg;
    logic [5:0]  sec_reg, min_reg;
    logic [4:0]  hr_reg;
    logic [2:0]  wd_reg;
    logic [7:0]  year_reg;
    logic [3:0]  mon_reg;
    logic        m_tvalid_reg;
    logic [es2ud_pkg::M_DATA_W-1:0] out_reg;

    logic [31:0] x;
    logic [31:0] q0, q;
    logic [31:0] r_raw;
    logic [6:0]  r;
    logic [5:0]  dconst;
    logic        leap;
    logic [8:0]  ylen;
    logic [4:0]  mlen;

    always_comb begin
        dconst = es2ud_pkg::div_const(cmd.div_sel);
        x      = (cmd.div_sel == es2ud_pkg::DIV_WDAY) ? t_reg + 32'd4 : t_reg;
        case (cmd.div_sel)
            es2ud_pkg::DIV_SEC:  q0 = {5'd0, prod_reg[63:37]};
            es2ud_pkg::DIV_MIN:  q0 = {5'd0, prod_reg[63:37]};
            es2ud_pkg::DIV_HOUR: q0 = {4'd0, prod_reg[63:36]};
            es2ud_pkg::DIV_WDAY: q0 = {2'd0, prod_reg[63:34]};
            default:             q0 = {5'd0, prod_reg[63:37]};
        endcase
        // estimate is exact or one low: remainder lies below twice the divisor
        r_raw = x - 32'(q0 * {26'd0, dconst});
        if (r_raw[7:0] >= {2'd0, dconst}) begin
            r = 7'(r_raw[7:0] - {2'd0, dconst});
            q = q0 + 32'd1;
        end else begin
            r = r_raw[6:0];
            q = q0;
        end
    end

    assign leap = es2ud_pkg::leap_year(year_reg);
    assign ylen = leap ? 9'd366 : 9'd365;
    assign mlen = es2ud_pkg::month_len(mon_reg, leap);

    always_comb begin
        t_next = t_reg;
        if (cmd.load) begin
            t_next = s_tdata;
        end else if (cmd.fix && cmd.div_sel != es2ud_pkg::DIV_WDAY) begin
            t_next = q;
        end else if (cmd.year_step) begin
            t_next = t_reg - {23'd0, ylen};
        end else if (cmd.month_step) begin
            t_next = t_reg - {27'd0, mlen};
        end
    end

    always_ff @(posedge aclk) begin
        t_reg <= t_next;
        if (cmd.mul) begin
            prod_reg <= {32'd0, x} * {32'd0, es2ud_pkg::div_magic(cmd.div_sel)};
        end
        if (cmd.fix) begin
            case (cmd.div_sel)
                es2ud_pkg::DIV_SEC:  sec_reg <= r[5:0];
                es2ud_pkg::DIV_MIN:  min_reg <= r[5:0];
                es2ud_pkg::DIV_HOUR: hr_reg  <= r[4:0];
                es2ud_pkg::DIV_WDAY: wd_reg  <= r[2:0];
                default:             sec_reg <= r[5:0];
            endcase
        end
        if (cmd.load) begin
            year_reg <= 8'd0;
        end else if (cmd.year_step) begin
            year_reg <= year_reg + 8'd1;
        end
        if (cmd.load) begin
            mon_reg <= 4'd0;
        end else if (cmd.month_step) begin
            mon_reg <= mon_reg + 4'd1;
        end
        if (cmd.out_load) begin
            out_reg <= {3'd0, 5'(t_reg[4:0] + 5'd1), mon_reg, year_reg,
                        wd_reg, hr_reg, min_reg, sec_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    assign sts.year_done  = t_reg < {23'd0, ylen};
    assign sts.month_done = (t_reg < {27'd0, mlen}) || (mon_reg == 4'd11);
    assign sts.out_free   = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_reg;

endmodule

`default_nettype wire

// ----- tb/sv/epoch_seconds_to_utc_date_top_tb.sv -----
// ----------------------------------------------------------------------------
// epoch_seconds_to_utc_date_top_tb
// Drives Unix timestamps into the converter and checks every broken-down UTC
// date against an in-bench calendar computation, with random stalls on both
// stream channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module epoch_seconds_to_utc_date_top_tb;

    localparam int unsigned FEBRUARY      = 1;
    localparam int unsigned DAYS_PER_YEAR = 365;
    localparam int unsigned SECS_PER_DAY  = 86400;
    localparam int unsigned LAST_FULL_DAY = 49709;
    localparam int unsigned IDLE_PCT      = 17;
    localparam int unsigned DRAIN_CYCLES  = 4000;
    localparam int unsigned TAIL_CYCLES   = 200;

    localparam int unsigned MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    typedef struct packed {
        logic [5:0] second;
        logic [5:0] minute;
        logic [4:0] hour;
        logic [2:0] weekday;
        logic [7:0] years;
        logic [3:0] month;
        logic [4:0] day;
    } utc_date_t;

    logic                           aclk = 1'b0;
    logic                           aresetn;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [es2ud_pkg::S_DATA_W-1:0] s_tdata;     // epoch_seconds
    logic                           m_tvalid;
    logic                           m_tready;
    logic [es2ud_pkg::M_DATA_W-1:0] m_tdata;     // second, minute, hour, weekday,
                                                 // years_since_1970, month_index,
                                                 // day_of_month

    utc_date_t   expected_dates [$];
    logic        idling_on;
    int unsigned sent_count;
    int unsigned checked_count;
    int unsigned mismatches;

    epoch_seconds_to_utc_date_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #4 aclk = ~aclk;

    function automatic logic gregorian_leap(input int unsigned yr);
        return (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
    endfunction

    function automatic utc_date_t to_utc_date(input logic [31:0] secs);
        utc_date_t   d;
        int unsigned t;
        int unsigned yr;
        int unsigned mon;
        int unsigned ylen;
        int unsigned mlen;
        logic        leap;
        t         = secs;
        d.second  = 6'(t % 60);
        t         = t / 60;
        d.minute  = 6'(t % 60);
        t         = t / 60;
        d.hour    = 5'(t % 24);
        t         = t / 24;
        d.weekday = 3'((t + 4) % 7);   // day 0 was a Thursday
        yr   = 1970;
        ylen = DAYS_PER_YEAR + {31'd0, gregorian_leap(yr)};
        while (t >= ylen) begin
            t    = t - ylen;
            yr   = yr + 1;
            ylen = DAYS_PER_YEAR + {31'd0, gregorian_leap(yr)};
        end
        leap = gregorian_leap(yr);
        mon  = 0;
        mlen = MONTH_DAYS[0];
        while (t >= mlen) begin
            t    = t - mlen;
            mon  = mon + 1;
            mlen = MONTH_DAYS[mon] + ((mon == FEBRUARY && leap) ? 1 : 0);
        end
        d.years = 8'(yr - 1970);
        d.month = 4'(mon);
        d.day   = 5'(t + 1);
        return d;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH %s", $realtime, msg);
        mismatches++;
    endtask

    // call at a rising edge; returns at the rising edge of the transfer
    task automatic send_seconds(input logic [31:0] secs);
        while (idling_on && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= secs;
        @(negedge aclk);
        while (!s_tready) @(negedge aclk);
        expected_dates.push_back(to_utc_date(secs));
        sent_count++;
        @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= !idling_on || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // outputs are settled at the falling edge; the transfer completes at the next rise
    always @(negedge aclk) begin : check_result
        utc_date_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_dates.size() == 0) begin
                report_mismatch($sformatf("unexpected transfer, tdata %h", m_tdata));
            end else begin
                want = expected_dates.pop_front();
                checked_count++;
                if (m_tdata[5:0] !== want.second)
                    report_mismatch($sformatf("second got %0d want %0d",
                                              m_tdata[5:0], want.second));
                if (m_tdata[11:6] !== want.minute)
                    report_mismatch($sformatf("minute got %0d want %0d",
                                              m_tdata[11:6], want.minute));
                if (m_tdata[16:12] !== want.hour)
                    report_mismatch($sformatf("hour got %0d want %0d",
                                              m_tdata[16:12], want.hour));
                if (m_tdata[19:17] !== want.weekday)
                    report_mismatch($sformatf("weekday got %0d want %0d",
                                              m_tdata[19:17], want.weekday));
                if (m_tdata[27:20] !== want.years)
                    report_mismatch($sformatf("years_since_1970 got %0d want %0d",
                                              m_tdata[27:20], want.years));
                if (m_tdata[31:28] !== want.month)
                    report_mismatch($sformatf("month_index got %0d want %0d",
                                              m_tdata[31:28], want.month));
                if (m_tdata[36:32] !== want.day)
                    report_mismatch($sformatf("day_of_month got %0d want %0d",
                                              m_tdata[36:32], want.day));
                if (m_tdata[39:37] !== 3'd0)
                    report_mismatch($sformatf("pad bits got %b", m_tdata[39:37]));
            end
        end
    end

    task automatic test_calendar_edges();
        logic [31:0] edges [$];
        edges = {32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
                 32'd68169600,      // 1972 leap day
                 32'd94694399,      // last second of leap year 1972
                 32'd946684799,     // end of 1999
                 32'd951782400,     // leap day of 2000, a 400-year century
                 32'd4107542399,    // 2100-02-28, century without leap day
                 32'd4107542400,    // 2100-03-01
                 32'd4291747200,    // 2106-01-01
                 32'h7FFF_FFFF, 32'h8000_0000, 32'hAAAA_AAAA, 32'h5555_5555,
                 32'hFFFF_FFFF};
        foreach (edges[i]) send_seconds(edges[i]);
    endtask

    task automatic test_random_times(input int unsigned count);
        logic [31:0] secs;
        for (int unsigned i = 0; i < count; i++) begin
            case ($urandom_range(3))
                0: secs = $urandom;
                1: secs = $urandom_range(LAST_FULL_DAY) * SECS_PER_DAY;
                2: secs = $urandom_range(LAST_FULL_DAY) * SECS_PER_DAY + SECS_PER_DAY - 1;
                default: secs = $urandom_range(LAST_FULL_DAY) * SECS_PER_DAY
                                + $urandom_range(SECS_PER_DAY - 1);
            endcase
            send_seconds(secs);
        end
    endtask

    // sender holds off until every pending date has come back
    task automatic test_drain_pause(input int unsigned bursts);
        for (int unsigned b = 0; b < bursts; b++) begin
            test_random_times($urandom_range(1, 8));
            s_tvalid <= 1'b0;
            while (expected_dates.size() != 0) @(posedge aclk);
        end
    endtask

    initial begin
        int unsigned waited;
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        idling_on     = 1'b0;
        sent_count    = 0;
        checked_count = 0;
        mismatches    = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        test_calendar_edges();
        test_random_times(150);          // back-to-back, no stalls
        idling_on <= 1'b1;
        test_random_times(300);
        test_drain_pause(10);
        s_tvalid <= 1'b0;

        waited = 0;
        while (expected_dates.size() != 0 && waited < DRAIN_CYCLES) begin
            @(posedge aclk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (expected_dates.size() != 0)
            report_mismatch($sformatf("%0d dates never returned", expected_dates.size()));

        $display("Covered day, year, leap-day and century edges plus random instants");
        $display("over the full 32-bit range: %0d sent, %0d checked, %0d mismatches",
                 sent_count, checked_count, mismatches);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("timeout: %0d sent, %0d checked", sent_count, checked_count);
        $display("end of test: mismatches");
        $finish;
    end

endmodule
